[src/k_smallest_distinct_distance_tracker_unit_macros.svh]
// Assertion macros used by the checker of the distance tracker.
`ifndef K_SMALLEST_DISTINCT_DISTANCE_TRACKER_UNIT_MACROS_SVH
`define K_SMALLEST_DISTINCT_DISTANCE_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KSDDT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define KSDDT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ksddt_pkg.sv]
package ksddt_pkg;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEFAULT     = 16;
    localparam int DIST_BITS_DEFAULT = 32;

    // Fixed widths of the request and result item fields, the k register and the member count.
    localparam int DIST_FIELD_W   = 32;
    localparam int INST_FIELD_W   = 16;
    localparam int SLOT_FIELD_W   = 4;
    localparam int FILLED_FIELD_W = 5;
    localparam int ACTIVE_W       = 5;
    localparam int MEMBER_W       = 16;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [MEMBER_W-1:0] MEMBER_MAX   = 16'hFFFF;

    // Action codes of a request.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Outcome codes of a result.
    typedef enum logic [2:0] {
        OUT_DROPPED  = 3'd0,
        OUT_JOINED   = 3'd1,
        OUT_NEW      = 3'd2,
        OUT_REPLACED = 3'd3,
        OUT_CLEARED  = 3'd4
    } outcome_t;

    // Sequencer states of the engine.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic                    action;
        logic [DIST_FIELD_W-1:0] distance;
        logic [INST_FIELD_W-1:0] instance_id;
    } in_item_t;

    typedef struct packed {
        outcome_t                  outcome;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [INST_FIELD_W-1:0]   instance_echo;
        logic [FILLED_FIELD_W-1:0] slots_filled;
    } out_item_t;

endpackage

[src/k_smallest_distinct_distance_tracker_unit.sv]
// Tracker of the k smallest distinct distances of a nearest-neighbor query.
//
// Requests enter on the s_ channel (valid/ready) as one in_item_t: an insert of
// a candidate distance with its instance id, or a clear of the table. Every
// request yields exactly one result on the m_ channel (out_item_t): outcome,
// affected slot, echoed instance id and the slot count after the request.
// The cfg channel writes active_slots (k); write it only while the block is idle.
//
// One request is processed at a time. Clears, new largest distances and drops
// skip the table search and go straight to ST_DONE. An insert that must search the
// table reads one slot per cycle from the slot memory, whose read port is
// registered, and stops early when a slot matches. The memory is read strictly
// after any earlier write-back, so no forwarding is needed.
//
// The result sits in an output register; s_ready rises again while it waits,
// so one request may be processed while the receiver stalls, after which the
// engine holds its result until the register frees. Reset empties the table and
// sets k to 16; the slot memory itself is not cleared.
module k_smallest_distinct_distance_tracker_unit
    import ksddt_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEFAULT,
    parameter int DIST_BITS = DIST_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ACTIVE_W-1:0] cfg_data
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int DSW     = (DIST_BITS < DIST_FIELD_W) ? DIST_BITS : DIST_FIELD_W;
    localparam int ENTRY_W = DSW + MEMBER_W;

    logic [ACTIVE_W-1:0] active_reg;
    logic [CNT_W-1:0]    k_eff;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic                res_valid;
    logic                res_ready;
    out_item_t           res_item;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_valid) begin
            active_reg <= cfg_data;
        end
    end

    // Clamp k to the range one to SLOTS.
    always_comb begin
        if (active_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(active_reg) > SLOTS) begin
            k_eff = CNT_W'(SLOTS);
        end else begin
            k_eff = CNT_W'(active_reg);
        end
    end

    ksddt_engine #(
        .SLOTS     (SLOTS),
        .DIST_BITS (DIST_BITS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W),
        .DSW       (DSW),
        .ENTRY_W   (ENTRY_W)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .k_eff     (k_eff),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ksddt_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W),
        .WIDTH  (ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register between the engine and the receiver.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/ksddt_slot_ram.sv]
module ksddt_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = 48
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ksddt_engine.sv]
module ksddt_engine
    import ksddt_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEFAULT,
    parameter int DIST_BITS = DIST_BITS_DEFAULT,
    parameter int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CNT_W     = $clog2(SLOTS + 1),
    parameter int DSW       = (DIST_BITS < DIST_FIELD_W) ? DIST_BITS : DIST_FIELD_W,
    parameter int ENTRY_W   = DSW + MEMBER_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CNT_W-1:0]   k_eff,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output out_item_t          res_item,
    output logic               wr_en,
    output logic [SLOT_W-1:0]  wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output logic               rd_en,
    output logic [SLOT_W-1:0]  rd_addr,
    input  logic [ENTRY_W-1:0] rd_data
);

    eng_state_t state_reg, state_next;

    logic [CNT_W-1:0]  filled_reg,     filled_next;
    logic [SLOT_W-1:0] lg_slot_reg,    lg_slot_next;
    logic [DSW-1:0]    lg_dist_reg,    lg_dist_next;
    logic [DSW-1:0]    d_reg,          d_next;
    logic [SLOT_W-1:0] chk_idx_reg,    chk_idx_next;
    logic              best_valid_reg, best_valid_next;
    logic [DSW-1:0]    best_dist_reg,  best_dist_next;
    logic [SLOT_W-1:0] best_slot_reg,  best_slot_next;
    out_item_t         res_reg,        res_next;

    logic              accept;
    logic [DSW-1:0]    d_in;
    logic              is_full;
    logic [DSW-1:0]    rd_dist;
    logic [MEMBER_W-1:0] rd_members;
    logic [MEMBER_W-1:0] members_inc;
    logic              hit;
    logic              last;
    logic [CNT_W-1:0]  chk_next_cnt;
    logic              take_best;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign d_in       = in_item.distance[DSW-1:0];
    assign is_full    = (filled_reg >= k_eff);
    assign rd_dist    = rd_data[ENTRY_W-1:MEMBER_W];
    assign rd_members = rd_data[MEMBER_W-1:0];
    assign members_inc = (rd_members == MEMBER_MAX) ? rd_members : rd_members + 1'b1;
    assign hit        = (rd_dist == d_reg);
    assign chk_next_cnt = CNT_W'(chk_idx_reg) + 1'b1;
    assign last       = (chk_next_cnt == filled_reg);
    // The entry just read becomes the best candidate for the next maximum, skipping
    // the slot that a replacement would overwrite.
    assign take_best  = (chk_idx_reg != lg_slot_reg) &&
                        (!best_valid_reg || (rd_dist > best_dist_reg));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_item.action == ACT_CLEAR || filled_reg == '0 || d_in > lg_dist_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory accesses and handshake outputs.
    always_comb begin
        filled_next     = filled_reg;
        lg_slot_next    = lg_slot_reg;
        lg_dist_next    = lg_dist_reg;
        d_next          = d_reg;
        chk_idx_next    = chk_idx_reg;
        best_valid_next = best_valid_reg;
        best_dist_next  = best_dist_reg;
        best_slot_next  = best_slot_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_DONE);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    d_next                 = d_in;
                    res_next.instance_echo = in_item.instance_id;
                    res_next.slot          = '0;
                    if (in_item.action == ACT_CLEAR) begin
                        // Empty the table; stored entries are left as they are.
                        filled_next           = '0;
                        lg_slot_next          = '0;
                        lg_dist_next          = '0;
                        res_next.outcome      = OUT_CLEARED;
                        res_next.slots_filled = '0;
                    end else if (filled_reg == '0 || (!is_full && d_in > lg_dist_reg)) begin
                        // A new largest distance takes the next free slot at once.
                        wr_en                 = 1'b1;
                        wr_addr               = filled_reg[SLOT_W-1:0];
                        wr_data               = {d_in, MEMBER_W'(1)};
                        lg_slot_next          = filled_reg[SLOT_W-1:0];
                        lg_dist_next          = d_in;
                        filled_next           = filled_reg + 1'b1;
                        res_next.outcome      = OUT_NEW;
                        res_next.slot         = SLOT_FIELD_W'(filled_reg);
                        res_next.slots_filled = FILLED_FIELD_W'(filled_reg + 1'b1);
                    end else if (d_in > lg_dist_reg) begin
                        res_next.outcome      = OUT_DROPPED;
                        res_next.slots_filled = FILLED_FIELD_W'(filled_reg);
                    end else begin
                        // Start the scan of the occupied slots at slot zero.
                        rd_en           = 1'b1;
                        rd_addr         = '0;
                        chk_idx_next    = '0;
                        best_valid_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // Matching slot: write back the incremented member count.
                    wr_en                 = 1'b1;
                    wr_addr               = chk_idx_reg;
                    wr_data               = {d_reg, members_inc};
                    res_next.outcome      = OUT_JOINED;
                    res_next.slot         = SLOT_FIELD_W'(chk_idx_reg);
                    res_next.slots_filled = FILLED_FIELD_W'(filled_reg);
                end else begin
                    if (take_best) begin
                        best_valid_next = 1'b1;
                        best_dist_next  = rd_dist;
                        best_slot_next  = chk_idx_reg;
                    end
                    if (last) begin
                        if (!is_full) begin
                            // No match while filling: take the next free slot.
                            wr_en                 = 1'b1;
                            wr_addr               = filled_reg[SLOT_W-1:0];
                            wr_data               = {d_reg, MEMBER_W'(1)};
                            filled_next           = filled_reg + 1'b1;
                            res_next.outcome      = OUT_NEW;
                            res_next.slot         = SLOT_FIELD_W'(filled_reg);
                            res_next.slots_filled = FILLED_FIELD_W'(filled_reg + 1'b1);
                        end else begin
                            // Overwrite the largest slot; the new maximum is the larger
                            // of the candidate and the best of the other slots.
                            wr_en                 = 1'b1;
                            wr_addr               = lg_slot_reg;
                            wr_data               = {d_reg, MEMBER_W'(1)};
                            res_next.outcome      = OUT_REPLACED;
                            res_next.slot         = SLOT_FIELD_W'(lg_slot_reg);
                            res_next.slots_filled = FILLED_FIELD_W'(filled_reg);
                            if (best_valid_next && best_dist_next > d_reg) begin
                                lg_dist_next = best_dist_next;
                                lg_slot_next = best_slot_next;
                            end else begin
                                lg_dist_next = d_reg;
                            end
                        end
                    end else begin
                        // Issue the read of the following slot.
                        rd_en        = 1'b1;
                        rd_addr      = chk_next_cnt[SLOT_W-1:0];
                        chk_idx_next = chk_next_cnt[SLOT_W-1:0];
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            lg_slot_reg <= '0;
            lg_dist_reg <= '0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            lg_slot_reg <= lg_slot_next;
            lg_dist_reg <= lg_dist_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        d_reg          <= d_next;
        chk_idx_reg    <= chk_idx_next;
        best_valid_reg <= best_valid_next;
        best_dist_reg  <= best_dist_next;
        best_slot_reg  <= best_slot_next;
        res_reg        <= res_next;
    end

    assign res_item = res_reg;

endmodule

[src/ksddt_checker.sv]
`include "k_smallest_distinct_distance_tracker_unit_macros.svh"

module ksddt_checker
    import ksddt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input in_item_t            s_data,
    input logic                m_valid,
    input logic                m_ready,
    input out_item_t           m_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [ACTIVE_W-1:0] cfg_data
);

    // A stalled result keeps its valid and its contents.
    `KSDDT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Requests are processed one at a time, so the input closes after an accept.
    `KSDDT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted while busy")

    // A clear reports an empty table and slot zero.
    `KSDDT_ASSERT_NOW(a_clear_empty, aclk, aresetn, m_valid && m_data.outcome == OUT_CLEARED, m_data.slots_filled == '0 && m_data.slot == '0, "clear result not empty")

    // A dropped candidate reports slot zero; any stored candidate leaves the table non-empty.
    `KSDDT_ASSERT_NOW(a_outcome_fields, aclk, aresetn, m_valid && (m_data.outcome == OUT_DROPPED || m_data.outcome == OUT_NEW || m_data.outcome == OUT_JOINED || m_data.outcome == OUT_REPLACED), m_data.slots_filled != '0 && (m_data.outcome != OUT_DROPPED || m_data.slot == '0), "insert result inconsistent")

endmodule

bind k_smallest_distinct_distance_tracker_unit ksddt_checker u_ksddt_checker (.*);

[tb/ksddt_result_checker.sv]
// Watches the request, result and register channels of the distance tracker.
// It keeps its own copy of the slot table, works out the result of each
// accepted request, and compares every accepted result with the oldest one
// still awaited.
module ksddt_result_checker
    import ksddt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  in_item_t            s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  out_item_t           m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [ACTIVE_W-1:0] cfg_data,
    output int                  error_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = SLOTS_DEFAULT;

    // Shadow of the slot table and of the largest entry.
    logic [DIST_FIELD_W-1:0] slot_dist [SLOTS];
    logic [MEMBER_W-1:0]     slot_count [SLOTS];
    int unsigned             filled;
    int unsigned             widest_slot;
    logic [DIST_FIELD_W-1:0] widest_dist;
    logic [ACTIVE_W-1:0]     k_setting;

    // Results still owed by the block, oldest first.
    out_item_t awaited_results[$];

    initial begin
        error_count = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // A setting of 0 behaves as 1, and anything above the table size as the size.
    function automatic int unsigned active_k();
        int unsigned k;
        k = 32'(k_setting);
        if (k < 1) begin
            k = 1;
        end
        if (k > SLOTS) begin
            k = SLOTS;
        end
        return k;
    endfunction

    // Index of the occupied slot holding the distance, or SLOTS when none does.
    function automatic int unsigned match_slot(logic [DIST_FIELD_W-1:0] cand_dist);
        for (int unsigned i = 0; i < filled && i < SLOTS; i++) begin
            if (slot_dist[i] == cand_dist) begin
                return i;
            end
        end
        return SLOTS;
    endfunction

    // The member count saturates instead of wrapping.
    function automatic void add_member(int unsigned idx);
        if (slot_count[idx] != MEMBER_MAX) begin
            slot_count[idx]++;
        end
    endfunction

    // Find the largest stored distance again; the lowest index wins a tie.
    function automatic void find_widest();
        widest_slot = 0;
        widest_dist = slot_dist[0];
        for (int unsigned i = 1; i < filled && i < SLOTS; i++) begin
            if (slot_dist[i] > widest_dist) begin
                widest_dist = slot_dist[i];
                widest_slot = i;
            end
        end
    endfunction

    // Apply one request to the shadow table and return the result it causes.
    function automatic out_item_t apply_request(in_item_t req);
        out_item_t   res;
        int unsigned k;
        int unsigned hit;
        k = active_k();
        res.outcome = OUT_DROPPED;
        res.slot = '0;
        res.instance_echo = req.instance_id;
        if (req.action == ACT_CLEAR) begin
            filled = 0;
            widest_slot = 0;
            widest_dist = '0;
            res.outcome = OUT_CLEARED;
        end else if (filled < k) begin
            // The table is still filling: join a match or take the next slot.
            if (filled == 0 || req.distance > widest_dist) begin
                widest_dist = req.distance;
                widest_slot = filled;
                hit = SLOTS;
            end else begin
                hit = match_slot(req.distance);
            end
            if (hit < SLOTS) begin
                add_member(hit);
                res.slot = SLOT_FIELD_W'(hit);
                res.outcome = OUT_JOINED;
            end else begin
                slot_dist[filled] = req.distance;
                slot_count[filled] = MEMBER_W'(1);
                res.slot = SLOT_FIELD_W'(filled);
                filled++;
                res.outcome = OUT_NEW;
            end
        end else if (req.distance > widest_dist) begin
            res.outcome = OUT_DROPPED;
        end else begin
            // Full table: join a match, or evict the largest slot.
            if (req.distance == widest_dist) begin
                hit = widest_slot;
            end else begin
                hit = match_slot(req.distance);
            end
            if (hit < SLOTS) begin
                add_member(hit);
                res.slot = SLOT_FIELD_W'(hit);
                res.outcome = OUT_JOINED;
            end else begin
                res.slot = SLOT_FIELD_W'(widest_slot);
                slot_dist[widest_slot] = req.distance;
                slot_count[widest_slot] = MEMBER_W'(1);
                find_widest();
                res.outcome = OUT_REPLACED;
            end
        end
        res.slots_filled = FILLED_FIELD_W'(filled);
        return res;
    endfunction

    // Results are compared before the request of the same edge is predicted,
    // so a result can never be matched with a request that arrives with it.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            filled = 0;
            widest_slot = 0;
            widest_dist = '0;
            k_setting = ACTIVE_RESET;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                k_setting = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result for instance %0d with no request pending",
                                              m_data.instance_echo));
                end else begin
                    want = awaited_results.pop_front();
                    check_field("outcome", 32'(m_data.outcome), 32'(want.outcome));
                    check_field("slot", 32'(m_data.slot), 32'(want.slot));
                    check_field("instance_echo", 32'(m_data.instance_echo),
                                32'(want.instance_echo));
                    check_field("slots_filled", 32'(m_data.slots_filled),
                                32'(want.slots_filled));
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_request(s_data));
            end
        end
        outstanding <= awaited_results.size();
    end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the distance tracker; checking is done by the
// result checker placed beside the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksddt_pkg::*;

    localparam int          ITEMS_PER_PHASE = 165;
    localparam int          PHASES          = 12;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    // Register setting of each random phase, extremes and out-of-range values included.
    localparam logic [ACTIVE_W-1:0] K_PLAN [PHASES] = '{
        5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd16, 5'd3, 5'd12, 5'd16
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data = ACTIVE_RESET;

    int          error_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    k_smallest_distinct_distance_tracker_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ksddt_result_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Offer one request after a random gap and wait until it is taken.
    task automatic send_request(logic action, logic [DIST_FIELD_W-1:0] cand_dist,
                                logic [INST_FIELD_W-1:0] inst);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{action: action, distance: cand_dist, instance_id: inst};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Write the slot-count register; only called while the block is idle.
    task automatic write_k(logic [ACTIVE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every awaited result, then let the engine drain.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly distances from a small pool so that queries see joins and
    // evictions; the rest are extremes or fully random words.
    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned pick;
        pick = $urandom_range(99);
        req.action = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_INSERT;
        if (pick < 70) begin
            req.distance = ($urandom_range(23) << 16) | ($urandom_range(1) << 15);
        end else if (pick < 80) begin
            req.distance = $urandom_range(1) ? '1 : '0;
        end else begin
            req.distance = $urandom();
        end
        req.instance_id = INST_FIELD_W'($urandom_range(16'hFFFF));
        return req;
    endfunction

    initial begin
        in_item_t req;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        snd_idle_pct = 8;
        rcv_idle_pct <= 65;

        // Three slots: fill, drop, join the largest, evict and find the largest again.
        write_k(5'd3);
        send_request(ACT_CLEAR, 32'd0, 16'h0000);
        send_request(ACT_INSERT, 32'd100, 16'hFFFF);
        send_request(ACT_INSERT, 32'd50, 16'h0001);
        send_request(ACT_INSERT, 32'd50, 16'h0002);
        send_request(ACT_INSERT, 32'd200, 16'hA5A5);
        send_request(ACT_INSERT, 32'd300, 16'h5A5A);
        send_request(ACT_INSERT, 32'd200, 16'h0003);
        send_request(ACT_INSERT, 32'd100, 16'h0004);
        send_request(ACT_INSERT, 32'd75, 16'h0005);
        send_request(ACT_INSERT, 32'd0, 16'h0006);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0007);
        send_request(ACT_INSERT, 32'd0, 16'h8000);
        settle();

        // A setting of zero keeps a single slot.
        write_k(5'd0);
        send_request(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0010);
        send_request(ACT_INSERT, 32'd7, 16'h0011);
        send_request(ACT_INSERT, 32'd7, 16'h0012);
        send_request(ACT_INSERT, 32'd9, 16'h0013);
        settle();

        // Grow the table, then lower the setting below the fill without a clear.
        write_k(5'd16);
        send_request(ACT_INSERT, 32'd40, 16'h0020);
        send_request(ACT_INSERT, 32'd30, 16'h0021);
        send_request(ACT_INSERT, 32'd20, 16'h0022);
        send_request(ACT_INSERT, 32'd10, 16'h0023);
        settle();
        write_k(5'd2);
        send_request(ACT_INSERT, 32'd50, 16'h0024);
        send_request(ACT_INSERT, 32'd20, 16'h0025);
        send_request(ACT_INSERT, 32'd5, 16'h0026);

        // Random phases, each under its register setting from the plan and the current idle pattern.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase == 4) begin
                snd_idle_pct = 65;
                rcv_idle_pct <= 8;
            end else if (phase == 8) begin
                snd_idle_pct = 0;
                rcv_idle_pct <= 0;
            end
            write_k(K_PLAN[phase]);
            if (phase == 8) begin
                hold_req <= 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                req = random_request();
                send_request(req.action, req.distance, req.instance_id);
            end
        end
        settle();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
